FILE: rtl/fwrlw_pkg.sv
package fwrlw_pkg;

    // Field widths of one transaction
    localparam int ID_W     = 32;
    localparam int PRIO_W   = 8;
    localparam int WAIT_W   = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes
    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_PUSH = 2'd0;
    localparam kind_t KIND_POP  = 2'd1;
    localparam kind_t KIND_KILL = 2'd2;

    // Status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // One stored process record
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [WAIT_W-1:0] wtime;
    } rec_t;

    // Result handed from the sequencer to the output register
    typedef struct packed {
        status_t          status;
        rec_t             rec;
        logic [OCC_W-1:0] occupancy;
    } result_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } seq_state_t;

endpackage

FILE: rtl/fifo_with_remove_longest_wait_unit.sv
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid / in_stall | kind, proc_id, prio, wait_time
// output  | out       | out_valid/out_stall | status, out_id, out_prio, out_wait, occupancy
//
// Push, refused push, empty pop or kill and unused kinds finish at the accept edge.
// Pop makes one memory read of the head, then the result is registered.
// Kill scans all n records held through the single read port, then compacts the records
// behind position p when the record at position p is neither head nor tail.
// Reset clears the head pointer and the fill count; the record memory is not cleared.
// One transaction is in flight at a time; a stalled result holds further input off.
module fifo_with_remove_longest_wait_unit
    import fwrlw_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KIND_W-1:0] kind,
    input  logic [ID_W-1:0]   proc_id,
    input  logic [PRIO_W-1:0] prio,
    input  logic [WAIT_W-1:0] wait_time,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]   out_id,
    output logic [PRIO_W-1:0] out_prio,
    output logic [WAIT_W-1:0] out_wait,
    output logic [OCC_W-1:0]  occupancy
);

    localparam int PTR_W = $clog2(DEPTH);

    logic             start;
    logic             busy;
    logic             seq_done;
    result_t          seq_res;
    rec_t             in_rec;
    logic             mem_wr_en;
    logic [PTR_W-1:0] mem_wr_addr;
    rec_t             mem_wr_data;
    logic             mem_rd_en;
    logic [PTR_W-1:0] mem_rd_addr;
    rec_t             mem_rd_data;
    logic             out_vld_reg, out_vld_next;
    result_t          out_res_reg;

    // Accept when idle and the output register is free or draining
    assign in_stall = busy || (out_vld_reg && out_stall);
    assign start    = in_valid && !in_stall;
    assign in_rec   = '{id: proc_id, prio: prio, wtime: wait_time};

    fwrlw_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .start_kind  (kind),
        .start_rec   (in_rec),
        .busy        (busy),
        .done        (seq_done),
        .res         (seq_res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    fwrlw_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Hold the result until taken
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (seq_done)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_done)
        begin
            out_res_reg <= seq_res;
        end
    end

    assign out_valid = out_vld_reg;
    assign status    = out_res_reg.status;
    assign out_id    = out_res_reg.rec.id;
    assign out_prio  = out_res_reg.rec.prio;
    assign out_wait  = out_res_reg.rec.wtime;
    assign occupancy = out_res_reg.occupancy;

    // An accepted transaction is either in progress or waiting at the output
    a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy || out_vld_reg))
        else $error("accepted transaction lost");

    // Only a removal carries record fields
    a_no_rec_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DONE) |-> (out_id == '0 && out_prio == '0 && out_wait == '0))
        else $error("record fields set on failed operation");

    // Empty status reports an empty queue
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (occupancy == '0))
        else $error("empty status with records held");

    // Occupancy stays within the depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 31 || 32'(occupancy) <= 32'(DEPTH)))
        else $error("occupancy above depth");

    // No new transaction enters while the sequencer works
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !start)
        else $error("transaction accepted while busy");

endmodule

FILE: rtl/fwrlw_mem.sv
module fwrlw_mem
    import fwrlw_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rec_t          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output rec_t          rd_data
);

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fwrlw_seq.sv
module fwrlw_seq
    import fwrlw_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  kind_t            start_kind,
    input  rec_t             start_rec,
    output logic             busy,
    output logic             done,
    output result_t          res,
    output logic             mem_wr_en,
    output logic [PTR_W-1:0] mem_wr_addr,
    output rec_t             mem_wr_data,
    output logic             mem_rd_en,
    output logic [PTR_W-1:0] mem_rd_addr,
    input  rec_t             mem_rd_data
);

    seq_state_t       state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [PTR_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [PTR_W-1:0] best_pos_reg, best_pos_next;
    rec_t             best_rec_reg, best_rec_next;
    status_t          res_status;
    rec_t             res_rec;
    logic [CNT_W+OCC_W-1:0] occ_ext;

    // Map a queue position to a memory address, wrapping at DEPTH
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                              input logic [PTR_W-1:0] lidx);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, lidx};
        if (sum >= (PTR_W+1)'(DEPTH))
        begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    // Scan and shift bookkeeping
    always_ff @(posedge clk)
    begin
        lim_reg      <= lim_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_pos_reg <= best_pos_next;
        best_rec_reg <= best_rec_next;
    end

    // Next state, memory accesses and result
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        lim_next      = lim_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        best_pos_next = best_pos_reg;
        best_rec_next = best_rec_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = phys(head_reg, count_reg[PTR_W-1:0]);
        mem_wr_data   = start_rec;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = phys(head_reg, rd_idx_reg[PTR_W-1:0]);
        done          = 1'b0;
        res_status    = ST_DONE;
        res_rec       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (start_kind)
                        KIND_PUSH:
                        begin
                            done = 1'b1;
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                // Append at the tail
                                mem_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_POP, KIND_KILL:
                        begin
                            if (count_reg == '0)
                            begin
                                done       = 1'b1;
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                // Pop scans the head only, kill scans all records
                                state_next  = S_SCAN;
                                lim_next    = (start_kind == KIND_POP) ? CNT_W'(1) : count_reg;
                                rd_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue the next read
                if (rd_idx_reg < lim_reg)
                begin
                    mem_rd_en    = 1'b1;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[PTR_W-1:0];
                end
                // Compare the returned record; earliest wins a tie
                if (cmp_vld_reg)
                begin
                    if (cmp_idx_reg == '0 || mem_rd_data.wtime > best_rec_reg.wtime)
                    begin
                        best_rec_next = mem_rd_data;
                        best_pos_next = cmp_idx_reg;
                    end
                    if (CNT_W'(cmp_idx_reg) + CNT_W'(1) == lim_reg)
                    begin
                        cmp_vld_next = 1'b0;
                        res_rec      = best_rec_next;
                        if (best_pos_next == '0)
                        begin
                            // Drop the head by advancing it
                            head_next  = phys(head_reg, PTR_W'(1));
                            count_next = count_reg - CNT_W'(1);
                            done       = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (CNT_W'(best_pos_next) + CNT_W'(1) == count_reg)
                        begin
                            // Drop the tail record
                            count_next = count_reg - CNT_W'(1);
                            done       = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next  = S_SHIFT;
                            rd_idx_next = CNT_W'(best_pos_next) + CNT_W'(1);
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // Read the record behind the gap
                if (rd_idx_reg < count_reg)
                begin
                    mem_rd_en    = 1'b1;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[PTR_W-1:0] - PTR_W'(1);
                end
                // Move it one place toward the head
                if (cmp_vld_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = phys(head_reg, cmp_idx_reg);
                    mem_wr_data = mem_rd_data;
                    if (CNT_W'(cmp_idx_reg) + CNT_W'(2) == count_reg)
                    begin
                        cmp_vld_next = 1'b0;
                        count_next   = count_reg - CNT_W'(1);
                        done         = 1'b1;
                        res_rec      = best_rec_reg;
                        state_next   = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign occ_ext = (CNT_W+OCC_W)'(count_next);
    assign res     = '{status: res_status, rec: res_rec, occupancy: occ_ext[OCC_W-1:0]};
    assign busy    = (state_reg != S_IDLE);

endmodule

FILE: verif/tb_fifo_with_remove_longest_wait_unit.sv
`timescale 1ns / 1ps

module tb_fifo_with_remove_longest_wait_unit;
    import fwrlw_pkg::*;

    localparam int DEPTH        = 16;
    localparam kind_t KIND_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 480;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [KIND_W-1:0]   kind = '0;
    logic [ID_W-1:0]     proc_id = '0;
    logic [PRIO_W-1:0]   prio = '0;
    logic [WAIT_W-1:0]   wait_time = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_id;
    logic [PRIO_W-1:0]   out_prio;
    logic [WAIT_W-1:0]   out_wait;
    logic [OCC_W-1:0]    occupancy;

    // Predicted queue contents and results still owed by the block
    rec_t    model_recs[$];
    result_t expected_results[$];

    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    int   error_count = 0;
    int   cycle_count = 0;
    logic hold_active = 1'b0;
    event hold_kick;

    fifo_with_remove_longest_wait_unit #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .proc_id   (proc_id),
        .prio      (prio),
        .wait_time (wait_time),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .out_id    (out_id),
        .out_prio  (out_prio),
        .out_wait  (out_wait),
        .occupancy (occupancy)
    );

    // Generate the 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one operation to the predicted queue and return the expected result
    function automatic result_t apply_queue_op(input kind_t op, input rec_t rec);
        result_t res;
        int      pos;
        res = '0;
        res.status = ST_DONE;
        case (op)
            KIND_PUSH:
            begin
                if (model_recs.size() >= DEPTH)
                    res.status = ST_FULL;
                else
                    model_recs.push_back(rec);
            end
            KIND_POP, KIND_KILL:
            begin
                if (model_recs.size() == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    pos = 0;
                    // Pick the longest wait; strict compare keeps the earliest on a tie
                    if (op == KIND_KILL)
                        for (int i = 1; i < model_recs.size(); i++)
                            if (model_recs[i].wtime > model_recs[pos].wtime)
                                pos = i;
                    res.rec = model_recs[pos];
                    model_recs.delete(pos);
                end
            end
            default: ;
        endcase
        res.occupancy = OCC_W'(model_recs.size());
        return res;
    endfunction

    // Offer one transaction, wait for its acceptance and log the prediction
    task automatic send_op(input kind_t op, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] pr, input logic [WAIT_W-1:0] wt);
        rec_t rec;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= op;
        proc_id   <= id;
        prio      <= pr;
        wait_time <= wt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rec.id    = id;
        rec.prio  = pr;
        rec.wtime = wt;
        expected_results.push_back(apply_queue_op(op, rec));
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, status %0d id 0x%0h",
                         $time, status, out_id);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", ID_W'(want.status), ID_W'(status));
                check_field("out_id", want.rec.id, out_id);
                check_field("out_prio", ID_W'(want.rec.prio), ID_W'(out_prio));
                check_field("out_wait", ID_W'(want.rec.wtime), ID_W'(out_wait));
                check_field("occupancy", ID_W'(want.occupancy), ID_W'(occupancy));
            end
        end
    end

    // Drive the receiver stall: random, or held high during a hold-off
    always @(negedge clk)
        out_stall <= hold_active || ($urandom_range(0, 99) < receiver_stall_pct);

    // Hold the receiver off for a long stretch when kicked
    always
    begin
        @(hold_kick);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active <= 1'b0;
    end

    // Pop, kill and unused kind on an empty queue
    task automatic test_empty_ops();
        send_op(KIND_POP, '0, '0, '0);
        send_op(KIND_KILL, '1, '1, '1);
        send_op(KIND_UNUSED, '1, '1, '1);
    endtask

    // Field extremes, tie on wait, removal at head and middle
    task automatic test_extremes_and_ties();
        send_op(KIND_PUSH, 32'h0000_0000, 8'h00, 16'h0000);
        send_op(KIND_PUSH, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_op(KIND_PUSH, 32'h1234_5678, 8'h5A, 16'hFFFF);
        send_op(KIND_PUSH, 32'h8000_0001, 8'h01, 16'h0007);
        send_op(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        // Tie on the maximum: the earlier record goes first
        send_op(KIND_KILL, '0, '0, '0);
        send_op(KIND_KILL, '0, '0, '0);
        send_op(KIND_PUSH, 32'h0F0F_0F0F, 8'h80, 16'h0003);
        // Maximum sits in the middle now
        send_op(KIND_KILL, '0, '0, '0);
        send_op(KIND_POP, '0, '0, '0);
        send_op(KIND_KILL, '0, '0, '0);
    endtask

    // Stall the output for a long hold, then push until the queue fills and refuses pushes
    task automatic test_full_under_hold();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        -> hold_kick;
        repeat (DEPTH + 4)
            send_op(KIND_PUSH, $urandom, PRIO_W'($urandom), WAIT_W'($urandom));
        send_op(KIND_KILL, '0, '0, '0);
        send_op(KIND_POP, '0, '0, '0);
    endtask

    // Random operations with a push bias that drifts to reach full and empty
    task automatic run_random_phase(input int n_items, input int idle_pct,
                                    input int stall_pct);
        int                push_w;
        int                pick;
        kind_t             op;
        logic [WAIT_W-1:0] wt;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        push_w = 50;
        for (int n = 0; n < n_items; n++)
        begin
            if (n % 40 == 0)
                push_w = $urandom_range(20, 80);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = KIND_UNUSED;
            else if (pick < 3 + push_w)
                op = KIND_PUSH;
            else if ($urandom_range(0, 2) != 0)
                op = KIND_KILL;
            else
                op = KIND_POP;
            // Favor small and extreme waits so ties come up often
            case ($urandom_range(0, 3))
                0: wt = WAIT_W'($urandom_range(0, 3));
                1: wt = ($urandom_range(0, 1) != 0) ? '1 : '0;
                default: wt = WAIT_W'($urandom);
            endcase
            send_op(op, $urandom, PRIO_W'($urandom), wt);
        end
    endtask

    // End the run if it takes far longer than any correct run could
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        test_empty_ops();
        test_extremes_and_ties();
        test_full_under_hold();
        run_random_phase(RANDOM_ITEMS, 0, 0);
        run_random_phase(RANDOM_ITEMS, 65, 0);
        run_random_phase(RANDOM_ITEMS, 0, 65);
        run_random_phase(RANDOM_ITEMS, 9, 9);
        in_valid <= 1'b0;
        // Drain outstanding results, then watch for stray ones
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
